// ----- hdl/rci_pkg.sv -----
// ----------------------------------------------------------------------------
// rci_pkg - shared definitions for the ray / cylinder intersection block
// Word format, register indexes, reset values and saturation helpers.
// ----------------------------------------------------------------------------
package rci_pkg;

	// fixed point word format (Q16.16)
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	// width of the exact sums of products before the shift
	localparam int ACC_BITS  = 68;

	// configuration register map
	localparam int NUM_REGS     = 7;
	localparam int REG_IDX_BITS = 3;
	localparam logic [REG_IDX_BITS-1:0] REG_AXIS_PX = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_AXIS_PY = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_AXIS_PZ = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_AXIS_DX = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_AXIS_DY = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_AXIS_DZ = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_RADIUS  = 3'd6;

	typedef logic signed [WORD_BITS-1:0] word_t;

	// reset values: axis along +y, unit radius
	localparam word_t       ONE_RST    = 32'sd65536;
	localparam logic [30:0] RADIUS_RST = 31'd65536;

	localparam logic signed [ACC_BITS-1:0] WMAX = 68'sd2147483647;
	localparam logic signed [ACC_BITS-1:0] WMIN = -68'sd2147483648;

	// clamp a wide signed value to one word
	function automatic word_t sat_word(input logic signed [ACC_BITS-1:0] v);
		word_t r;
		if (v > WMAX) begin
			r = 32'sh7fffffff;
		end else if (v < WMIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[WORD_BITS-1:0];
		end
		return r;
	endfunction

	// magnitude of a word, as an unsigned value
	function automatic logic [WORD_BITS-1:0] mag_word(input word_t v);
		logic [WORD_BITS-1:0] u;
		u = v;
		return v[WORD_BITS-1] ? (~u + 32'd1) : u;
	endfunction

endpackage

// ----- hdl/ray_cylinder_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_cylinder_intersect - ray against infinite cylinder, Q16.16
// Pipelined quadratic set-up, square root and root division, plus a
// sequential axis normaliser run after each axis direction write.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the axis
//    point, axis direction and radius. Indexes beyond the map are dropped.
//  - A write to an axis direction register starts the normaliser, which
//    runs 3 squares, 32 root steps and 3 x 48 divide steps. While it
//    runs, cfg_ready is low and in_stall is high.
//  - in channel: one ray per transfer (in_valid high, in_stall low).
//  - out channel: one result per ray, in order, while out_stall is low.
//  - Throughput is one ray per cycle while the normaliser is idle and no
//    output stall backs up the pipeline: 7 set-up stages, 9 root stages
//    (4 bits each), one numerator stage, 8 divide stages (4 quotient bits
//    each), and the output register.
//  - When the receiver stalls, the result holds in the output register and
//    upstream stages keep filling until each holds a ray; bubbles collapse.
//  - Reset (arst_n low) empties the pipeline and restores the default
//    cylinder: axis through the origin along +y, radius 1.0.
// ----------------------------------------------------------------------------
module ray_cylinder_intersect (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [rci_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	// ray input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [31:0] ray_origin_x,
	input  logic signed [31:0] ray_origin_y,
	input  logic signed [31:0] ray_origin_z,
	input  logic signed [31:0] ray_dir_x,
	input  logic signed [31:0] ray_dir_y,
	input  logic signed [31:0] ray_dir_z,
	input  logic        cmd,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic signed [31:0] near_dist,
	output logic signed [31:0] far_dist,
	output logic        parallel_flag,
	output logic        query_tag
);

	localparam int NSTAGE = 26;
	localparam int SQ_N   = 9;
	localparam int DV_N   = 8;
	localparam int SQ_0   = 7;
	localparam int NUM_ST = 16;
	localparam int DV_0   = 17;
	localparam int OUT_ST = 25;

	localparam logic [1:0] NRM_IDLE = 2'd0;
	localparam logic [1:0] NRM_LEN  = 2'd1;
	localparam logic [1:0] NRM_SQRT = 2'd2;
	localparam logic [1:0] NRM_DIV  = 2'd3;
	localparam logic [5:0] NRM_SQRT_LAST = 6'd31;
	localparam logic [5:0] NRM_DIV_LAST  = 6'd47;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic               hit;
		logic               par;
		logic               tag;
	} cr_t;

	typedef struct packed {
		logic [39:0] rem;
		logic [35:0] root;
		logic [71:0] rad;
	} sq_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] quo;
		logic [31:0] lo;
	} dv_t;

	typedef struct packed {
		logic [32:0] den;
		logic        ovf0;
		logic        ovf1;
		logic        neg0;
		logic        neg1;
	} dc_t;

	// four root steps: two radicand bits each
	function automatic sq_t sq_step4(input sq_t x);
		sq_t         y;
		logic [39:0] rn;
		logic [39:0] tr;
		y = x;
		for (int t = 0; t < 4; t++) begin
			rn = {y.rem[37:0], y.rad[71:70]};
			tr = {2'b00, y.root, 2'b01};
			y.rad = {y.rad[69:0], 2'b00};
			if (rn >= tr) begin
				y.rem  = rn - tr;
				y.root = {y.root[34:0], 1'b1};
			end else begin
				y.rem  = rn;
				y.root = {y.root[34:0], 1'b0};
			end
		end
		return y;
	endfunction

	// four restoring divide steps
	function automatic dv_t dv_step4(input dv_t x, input logic [32:0] den);
		dv_t         y;
		logic [33:0] rn;
		y = x;
		for (int t = 0; t < 4; t++) begin
			rn   = {y.rem, y.lo[31]};
			y.lo = {y.lo[30:0], 1'b0};
			if (rn >= {1'b0, den}) begin
				y.rem = 33'(rn - {1'b0, den});
				y.quo = {y.quo[30:0], 1'b1};
			end else begin
				y.rem = rn[32:0];
				y.quo = {y.quo[30:0], 1'b0};
			end
		end
		return y;
	endfunction

	// configuration state
	rci_pkg::word_t ap_q [3];
	rci_pkg::word_t ad_q [3];
	rci_pkg::word_t n_q  [3];
	logic [30:0]    rad_q;

	// normaliser
	logic [1:0]  nrm_state_q;
	logic [5:0]  nrm_cnt_q;
	logic [1:0]  nrm_comp_q;
	logic [63:0] len2_q;
	logic [35:0] nrt_rem_q;
	logic [31:0] nrt_root_q;
	logic [31:0] ndv_rem_q;
	logic [47:0] ndv_num_q;
	logic [31:0] ndv_quo_q;

	logic        cfg_wr;
	logic        nrm_start;
	logic        busy;
	logic [31:0] ad_mag [3];
	logic [31:0] mag_sel;
	logic [31:0] mag_nxt;
	logic [63:0] sq_len;
	logic [35:0] nrt_rn;
	logic [35:0] nrt_tr;
	logic        nrt_ge;
	logic [32:0] ndv_rn;
	logic        ndv_ge;
	logic [31:0] ndv_quo_nx;
	rci_pkg::word_t n_val;

	assign cfg_wr    = cfg_valid & cfg_ready;
	assign busy      = (nrm_state_q != NRM_IDLE);
	assign cfg_ready = !busy;
	assign nrm_start = cfg_wr &&
		(cfg_index inside {rci_pkg::REG_AXIS_DX, rci_pkg::REG_AXIS_DY,
			rci_pkg::REG_AXIS_DZ});

	// normaliser datapath terms
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ad_mag[i] = rci_pkg::mag_word(ad_q[i]);
		end
		mag_sel    = ad_mag[nrm_comp_q];
		mag_nxt    = (nrm_comp_q == 2'd0) ? ad_mag[1] : ad_mag[2];
		sq_len     = 64'(mag_sel) * 64'(mag_sel);
		nrt_rn     = {nrt_rem_q[33:0], len2_q[63:62]};
		nrt_tr     = {2'b00, nrt_root_q, 2'b01};
		nrt_ge     = (nrt_rn >= nrt_tr);
		ndv_rn     = {ndv_rem_q, ndv_num_q[47]};
		ndv_ge     = (ndv_rn >= {1'b0, nrt_root_q});
		ndv_quo_nx = {ndv_quo_q[30:0], ndv_ge};
		if (nrt_root_q == 32'd0) begin
			n_val = '0;
		end else if (ad_q[nrm_comp_q][31]) begin
			n_val = -$signed(ndv_quo_nx);
		end else begin
			n_val = $signed(ndv_quo_nx);
		end
	end

	// register writes and normaliser sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_q[0] <= '0;
			ap_q[1] <= '0;
			ap_q[2] <= '0;
			ad_q[0] <= '0;
			ad_q[1] <= rci_pkg::ONE_RST;
			ad_q[2] <= '0;
			n_q[0]  <= '0;
			n_q[1]  <= rci_pkg::ONE_RST;
			n_q[2]  <= '0;
			rad_q   <= rci_pkg::RADIUS_RST;
			nrm_state_q <= NRM_IDLE;
			nrm_cnt_q   <= '0;
			nrm_comp_q  <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					rci_pkg::REG_AXIS_PX: ap_q[0] <= cfg_data;
					rci_pkg::REG_AXIS_PY: ap_q[1] <= cfg_data;
					rci_pkg::REG_AXIS_PZ: ap_q[2] <= cfg_data;
					rci_pkg::REG_AXIS_DX: ad_q[0] <= cfg_data;
					rci_pkg::REG_AXIS_DY: ad_q[1] <= cfg_data;
					rci_pkg::REG_AXIS_DZ: ad_q[2] <= cfg_data;
					rci_pkg::REG_RADIUS:  rad_q   <= cfg_data[30:0];
					default: ;
				endcase
			end
			case (nrm_state_q)
				NRM_IDLE: begin
					if (nrm_start) begin
						nrm_state_q <= NRM_LEN;
						nrm_comp_q  <= '0;
					end
				end
				NRM_LEN: begin
					if (nrm_comp_q == 2'd2) begin
						nrm_state_q <= NRM_SQRT;
						nrm_cnt_q   <= '0;
						nrm_comp_q  <= '0;
					end else begin
						nrm_comp_q <= nrm_comp_q + 2'd1;
					end
				end
				NRM_SQRT: begin
					if (nrm_cnt_q == NRM_SQRT_LAST) begin
						nrm_state_q <= NRM_DIV;
						nrm_cnt_q   <= '0;
					end else begin
						nrm_cnt_q <= nrm_cnt_q + 6'd1;
					end
				end
				NRM_DIV: begin
					if (nrm_cnt_q == NRM_DIV_LAST) begin
						n_q[nrm_comp_q] <= n_val;
						nrm_cnt_q       <= '0;
						if (nrm_comp_q == 2'd2) begin
							nrm_state_q <= NRM_IDLE;
						end else begin
							nrm_comp_q <= nrm_comp_q + 2'd1;
						end
					end else begin
						nrm_cnt_q <= nrm_cnt_q + 6'd1;
					end
				end
				default: nrm_state_q <= NRM_IDLE;
			endcase
		end
	end

	// normaliser arithmetic: sum of squares, bit-serial root, then divides
	always_ff @(posedge clk) begin
		case (nrm_state_q)
			NRM_IDLE: begin
				if (nrm_start) len2_q <= '0;
			end
			NRM_LEN: begin
				len2_q     <= len2_q + sq_len;
				nrt_rem_q  <= '0;
				nrt_root_q <= '0;
			end
			NRM_SQRT: begin
				len2_q     <= {len2_q[61:0], 2'b00};
				nrt_rem_q  <= nrt_ge ? (nrt_rn - nrt_tr) : nrt_rn;
				nrt_root_q <= {nrt_root_q[30:0], nrt_ge};
				ndv_rem_q  <= '0;
				ndv_quo_q  <= '0;
				ndv_num_q  <= {ad_mag[0], 16'd0};
			end
			NRM_DIV: begin
				if (nrm_cnt_q == NRM_DIV_LAST) begin
					ndv_rem_q <= '0;
					ndv_quo_q <= '0;
					ndv_num_q <= {mag_nxt, 16'd0};
				end else begin
					ndv_rem_q <= ndv_ge ? 32'(ndv_rn - {1'b0, nrt_root_q}) : ndv_rn[31:0];
					ndv_quo_q <= ndv_quo_nx;
					ndv_num_q <= {ndv_num_q[46:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// pipeline flow control: a stage loads when empty or when the next loads
	logic [NSTAGE-1:0] vld_q;
	logic [NSTAGE-1:0] en;

	always_comb begin
		en[NSTAGE-1] = !vld_q[NSTAGE-1] | !out_stall;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] | en[k+1];
		end
	end

	assign in_stall = busy | !en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_valid & !busy;
			for (int k = 1; k < NSTAGE; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: origin relative to the axis point
	rci_pkg::word_t org_in [3];
	rci_pkg::word_t dir_in [3];
	rci_pkg::word_t o_s1 [3];
	rci_pkg::word_t d_s1 [3];
	logic           tag_s1;

	assign org_in[0] = ray_origin_x;
	assign org_in[1] = ray_origin_y;
	assign org_in[2] = ray_origin_z;
	assign dir_in[0] = ray_dir_x;
	assign dir_in[1] = ray_dir_y;
	assign dir_in[2] = ray_dir_z;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				o_s1[i] <= rci_pkg::sat_word(68'(org_in[i]) - 68'(ap_q[i]));
				d_s1[i] <= dir_in[i];
			end
			tag_s1 <= cmd;
		end
	end

	// stage 2: cross product terms, r = d x n and q = o x n
	logic signed [63:0] pr_a_s2 [3];
	logic signed [63:0] pr_b_s2 [3];
	logic signed [63:0] pq_a_s2 [3];
	logic signed [63:0] pq_b_s2 [3];
	logic               tag_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pr_a_s2[0] <= 64'(d_s1[1]) * 64'(n_q[2]);
			pr_b_s2[0] <= 64'(d_s1[2]) * 64'(n_q[1]);
			pr_a_s2[1] <= 64'(d_s1[2]) * 64'(n_q[0]);
			pr_b_s2[1] <= 64'(d_s1[0]) * 64'(n_q[2]);
			pr_a_s2[2] <= 64'(d_s1[0]) * 64'(n_q[1]);
			pr_b_s2[2] <= 64'(d_s1[1]) * 64'(n_q[0]);
			pq_a_s2[0] <= 64'(o_s1[1]) * 64'(n_q[2]);
			pq_b_s2[0] <= 64'(o_s1[2]) * 64'(n_q[1]);
			pq_a_s2[1] <= 64'(o_s1[2]) * 64'(n_q[0]);
			pq_b_s2[1] <= 64'(o_s1[0]) * 64'(n_q[2]);
			pq_a_s2[2] <= 64'(o_s1[0]) * 64'(n_q[1]);
			pq_b_s2[2] <= 64'(o_s1[1]) * 64'(n_q[0]);
			tag_s2     <= tag_s1;
		end
	end

	// stage 3: cross product components
	rci_pkg::word_t r_s3 [3];
	rci_pkg::word_t q_s3 [3];
	logic           tag_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				r_s3[i] <= rci_pkg::sat_word((68'(pr_a_s2[i]) - 68'(pr_b_s2[i]))
					>>> rci_pkg::FRAC_BITS);
				q_s3[i] <= rci_pkg::sat_word((68'(pq_a_s2[i]) - 68'(pq_b_s2[i]))
					>>> rci_pkg::FRAC_BITS);
			end
			tag_s3 <= tag_s2;
		end
	end

	// stage 4: dot product terms and radius squared
	logic signed [63:0] rr_s4 [3];
	logic signed [63:0] qr_s4 [3];
	logic signed [63:0] qq_s4 [3];
	logic [63:0]        rad2_s4;
	logic               tag_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				rr_s4[i] <= 64'(r_s3[i]) * 64'(r_s3[i]);
				qr_s4[i] <= 64'(q_s3[i]) * 64'(r_s3[i]);
				qq_s4[i] <= 64'(q_s3[i]) * 64'(q_s3[i]);
			end
			rad2_s4 <= 64'(rad_q) * 64'(rad_q);
			tag_s4  <= tag_s3;
		end
	end

	// stage 5: quadratic coefficients a, b, c
	rci_pkg::word_t a_s5;
	rci_pkg::word_t b_s5;
	rci_pkg::word_t c_s5;
	logic           tag_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			a_s5 <= rci_pkg::sat_word((68'(rr_s4[0]) + 68'(rr_s4[1]) + 68'(rr_s4[2]))
				>>> rci_pkg::FRAC_BITS);
			b_s5 <= rci_pkg::sat_word(((68'(qr_s4[0]) + 68'(qr_s4[1]) + 68'(qr_s4[2]))
				<<< 1) >>> rci_pkg::FRAC_BITS);
			c_s5 <= rci_pkg::sat_word((68'(qq_s4[0]) + 68'(qq_s4[1]) + 68'(qq_s4[2])
				- $signed({4'b0000, rad2_s4})) >>> rci_pkg::FRAC_BITS);
			tag_s5 <= tag_s4;
		end
	end

	// stage 6: b*b and a*c
	logic signed [63:0] bb_s6;
	logic signed [63:0] ac_s6;
	rci_pkg::word_t     a_s6;
	rci_pkg::word_t     b_s6;
	logic               tag_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			bb_s6  <= 64'(b_s5) * 64'(b_s5);
			ac_s6  <= 64'(a_s5) * 64'(c_s5);
			a_s6   <= a_s5;
			b_s6   <= b_s5;
			tag_s6 <= tag_s5;
		end
	end

	// stage 7: exact discriminant, hit and parallel flags
	logic signed [67:0] disc_c;
	logic [65:0]        rad_s7;
	cr_t                cr_s7;

	assign disc_c = 68'(bb_s6) - (68'(ac_s6) <<< 2);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			rad_s7    <= disc_c[67] ? 66'd0 : disc_c[65:0];
			cr_s7.a   <= a_s6;
			cr_s7.b   <= b_s6;
			cr_s7.hit <= !disc_c[67];
			cr_s7.par <= (a_s6 == '0);
			cr_s7.tag <= tag_s6;
		end
	end

	// stages 8 to 16: square root of the discriminant, four bits a stage
	sq_t sq_nx [SQ_N];
	sq_t sq_s8to16 [SQ_N];
	cr_t cr_s8to16 [SQ_N];

	always_comb begin
		sq_nx[0] = sq_step4({40'd0, 36'd0, {6'd0, rad_s7}});
		for (int j = 1; j < SQ_N; j++) begin
			sq_nx[j] = sq_step4(sq_s8to16[j-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[SQ_0]) cr_s8to16[0] <= cr_s7;
		for (int j = 1; j < SQ_N; j++) begin
			if (en[SQ_0+j]) cr_s8to16[j] <= cr_s8to16[j-1];
		end
		for (int j = 0; j < SQ_N; j++) begin
			if (en[SQ_0+j]) sq_s8to16[j] <= sq_nx[j];
		end
	end

	// stage 17: numerators -(b + s), -(b - s), divisor 2a, overflow check
	cr_t                cr_in17;
	logic signed [35:0] s_sgn;
	logic signed [35:0] num0;
	logic signed [35:0] num1;
	logic [34:0]        mag0;
	logic [34:0]        mag1;
	logic [32:0]        den_c;
	dv_t                dv0_s17;
	dv_t                dv1_s17;
	dc_t                dc_s17;
	cr_t                cr_s17;

	always_comb begin
		cr_in17 = cr_s8to16[SQ_N-1];
		s_sgn   = $signed({1'b0, sq_s8to16[SQ_N-1].root[34:0]});
		num0    = -(36'(cr_in17.b) + s_sgn);
		num1    = -(36'(cr_in17.b) - s_sgn);
		mag0    = num0[35] ? 35'(-num0) : 35'(num0);
		mag1    = num1[35] ? 35'(-num1) : 35'(num1);
		den_c   = {cr_in17.a, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en[NUM_ST]) begin
			dv0_s17     <= '{rem: {14'd0, mag0[34:16]}, quo: 32'd0, lo: {mag0[15:0], 16'd0}};
			dv1_s17     <= '{rem: {14'd0, mag1[34:16]}, quo: 32'd0, lo: {mag1[15:0], 16'd0}};
			dc_s17.den  <= den_c;
			dc_s17.ovf0 <= ({14'd0, mag0[34:16]} >= den_c);
			dc_s17.ovf1 <= ({14'd0, mag1[34:16]} >= den_c);
			dc_s17.neg0 <= num0[35];
			dc_s17.neg1 <= num1[35];
			cr_s17      <= cr_in17;
		end
	end

	// stages 18 to 25: two dividers, four quotient bits a stage
	dv_t dv0_nx [DV_N];
	dv_t dv1_nx [DV_N];
	dv_t dv0_s18to25 [DV_N];
	dv_t dv1_s18to25 [DV_N];
	dc_t dc_s18to25 [DV_N];
	cr_t cr_s18to25 [DV_N];

	always_comb begin
		dv0_nx[0] = dv_step4(dv0_s17, dc_s17.den);
		dv1_nx[0] = dv_step4(dv1_s17, dc_s17.den);
		for (int j = 1; j < DV_N; j++) begin
			dv0_nx[j] = dv_step4(dv0_s18to25[j-1], dc_s18to25[j-1].den);
			dv1_nx[j] = dv_step4(dv1_s18to25[j-1], dc_s18to25[j-1].den);
		end
	end

	always_ff @(posedge clk) begin
		if (en[DV_0]) begin
			dc_s18to25[0] <= dc_s17;
			cr_s18to25[0] <= cr_s17;
		end
		for (int j = 1; j < DV_N; j++) begin
			if (en[DV_0+j]) begin
				dc_s18to25[j] <= dc_s18to25[j-1];
				cr_s18to25[j] <= cr_s18to25[j-1];
			end
		end
		for (int j = 0; j < DV_N; j++) begin
			if (en[DV_0+j]) begin
				dv0_s18to25[j] <= dv0_nx[j];
				dv1_s18to25[j] <= dv1_nx[j];
			end
		end
	end

	// stage 26: saturate, order by magnitude, zero on miss or parallel
	dc_t                dc_f;
	cr_t                cr_f;
	logic [31:0]        m0;
	logic [31:0]        m1;
	logic [31:0]        mt0;
	logic [31:0]        mt1;
	logic signed [31:0] t0;
	logic signed [31:0] t1;
	logic               hit_s26;
	logic signed [31:0] near_s26;
	logic signed [31:0] far_s26;
	logic               par_s26;
	logic               tag_s26;

	always_comb begin
		dc_f = dc_s18to25[DV_N-1];
		cr_f = cr_s18to25[DV_N-1];
		m0 = (dc_f.ovf0 || (dv0_s18to25[DV_N-1].quo > 32'h80000000)) ?
			32'h80000000 : dv0_s18to25[DV_N-1].quo;
		m1 = (dc_f.ovf1 || (dv1_s18to25[DV_N-1].quo > 32'h80000000)) ?
			32'h80000000 : dv1_s18to25[DV_N-1].quo;
		// positive results clamp one short of the negative limit
		mt0 = (!dc_f.neg0 && m0[31]) ? 32'h7fffffff : m0;
		mt1 = (!dc_f.neg1 && m1[31]) ? 32'h7fffffff : m1;
		t0  = dc_f.neg0 ? -$signed(mt0) : $signed(mt0);
		t1  = dc_f.neg1 ? -$signed(mt1) : $signed(mt1);
	end

	always_ff @(posedge clk) begin
		if (en[OUT_ST]) begin
			hit_s26 <= cr_f.hit;
			par_s26 <= cr_f.par;
			tag_s26 <= cr_f.tag;
			if (!cr_f.hit || cr_f.par) begin
				near_s26 <= '0;
				far_s26  <= '0;
			end else if (mt0 > mt1) begin
				near_s26 <= t1;
				far_s26  <= t0;
			end else begin
				near_s26 <= t0;
				far_s26  <= t1;
			end
		end
	end

	assign out_valid     = vld_q[OUT_ST];
	assign hit           = hit_s26;
	assign near_dist     = near_s26;
	assign far_dist      = far_s26;
	assign parallel_flag = par_s26;
	assign query_tag     = tag_s26;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the ray / infinite cylinder intersection
// Drives rays and register writes through valid/stall and valid/ready
// channels with random gaps and output stalls. Each accepted ray is run
// through a bit-exact fixed point predictor (or a hand-worked result for the
// simple directed rows) and every result transfer is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;

	typedef logic signed [127:0] acc_t;
	typedef logic signed [31:0] vec3_t [3];

	typedef struct {
		logic              hit;
		logic signed [31:0] near_d;
		logic signed [31:0] far_d;
		logic              par;
		logic              tag;
	} isect_t;

	typedef struct {
		logic signed [31:0] ox, oy, oz, dx, dy, dz;
		logic              kind;
		logic              known;
		isect_t            res;
	} ray_row_t;

	localparam int ONE      = 65536;
	localparam int LATENCY  = 26;
	localparam int LIMIT    = 400000;
	localparam int N_PHASES = 12;
	localparam int PER_PHASE = 50;
	localparam logic [rci_pkg::REG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [rci_pkg::REG_IDX_BITS-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic signed [31:0] ray_origin_x = '0, ray_origin_y = '0, ray_origin_z = '0;
	logic signed [31:0] ray_dir_x = '0, ray_dir_y = '0, ray_dir_z = '0;
	logic        cmd = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        hit;
	logic signed [31:0] near_dist, far_dist;
	logic        parallel_flag, query_tag;

	// local copy of the cylinder registers
	logic [31:0] cyl_regs [rci_pkg::NUM_REGS];
	isect_t      pending_hits [$];
	int          fails = 0;
	int          cycles = 0;
	int          stall_left = 0;

	ray_cylinder_intersect dut (.*);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---------------- fixed point predictor ----------------
	function automatic logic signed [31:0] clamp_word(input acc_t v);
		if (v > acc_t'(32'sh7fffffff)) return 32'sh7fffffff;
		if (v < acc_t'(32'sh80000000)) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
		logic [63:0]  r;
		logic [63:0]  c;
		logic [127:0] sq;
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			c = r | (64'd1 << k);
			sq = {64'd0, c} * {64'd0, c};
			if (sq <= x) r = c;
		end
		return r;
	endfunction

	function automatic acc_t dot_exact(input vec3_t u, input vec3_t v);
		return acc_t'(u[0]) * acc_t'(v[0]) + acc_t'(u[1]) * acc_t'(v[1])
			+ acc_t'(u[2]) * acc_t'(v[2]);
	endfunction

	function automatic vec3_t cross_q(input vec3_t u, input vec3_t v);
		vec3_t w;
		w[0] = clamp_word((acc_t'(u[1]) * acc_t'(v[2]) - acc_t'(u[2]) * acc_t'(v[1])) >>> 16);
		w[1] = clamp_word((acc_t'(u[2]) * acc_t'(v[0]) - acc_t'(u[0]) * acc_t'(v[2])) >>> 16);
		w[2] = clamp_word((acc_t'(u[0]) * acc_t'(v[1]) - acc_t'(u[1]) * acc_t'(v[0])) >>> 16);
		return w;
	endfunction

	// num / den in Q16.16, truncated toward zero, clamped to 32 bits
	function automatic logic signed [31:0] root_div(input acc_t num, input acc_t den);
		acc_t un, qt, m;
		un = (num < 0) ? -num : num;
		qt = (un <<< 16) / den;
		m  = (qt > acc_t'(64'sd2147483648)) ? acc_t'(64'sd2147483648) : qt;
		if (num < 0) return clamp_word(-m);
		return clamp_word(m);
	endfunction

	function automatic isect_t cylinder_hit(input vec3_t org, input vec3_t dir,
			input logic kind);
		vec3_t  off, ad, nrm, rv, qv;
		acc_t   a, b, c, disc, rad, t0, t1, den, s;
		logic [63:0] len;
		isect_t res;
		for (int i = 0; i < 3; i++) begin
			off[i] = clamp_word(acc_t'(org[i]) - acc_t'($signed(cyl_regs[i])));
			ad[i]  = $signed(cyl_regs[3 + i]);
		end
		rad = acc_t'({1'b0, cyl_regs[rci_pkg::REG_RADIUS][30:0]});
		len = floor_sqrt(dot_exact(ad, ad));
		for (int i = 0; i < 3; i++) begin
			if (len == 0) begin
				nrm[i] = '0;
			end else begin
				t0 = ((ad[i] < 0) ? -acc_t'(ad[i]) : acc_t'(ad[i])) <<< 16;
				t0 = t0 / acc_t'({64'd0, len});
				nrm[i] = clamp_word((ad[i] < 0) ? -t0 : t0);
			end
		end
		rv = cross_q(dir, nrm);
		qv = cross_q(off, nrm);
		a = acc_t'(clamp_word(dot_exact(rv, rv) >>> 16));
		b = acc_t'(clamp_word((dot_exact(qv, rv) * 2) >>> 16));
		c = acc_t'(clamp_word((dot_exact(qv, qv) - rad * rad) >>> 16));
		disc = b * b - 4 * a * c;
		res.hit = (disc >= 0);
		res.par = (a == 0);
		res.tag = kind;
		res.near_d = '0;
		res.far_d = '0;
		if (res.hit && !res.par) begin
			s = acc_t'({64'd0, floor_sqrt(disc)});
			den = 2 * a;
			t0 = acc_t'(root_div(-(b + s), den));
			t1 = acc_t'(root_div(-(b - s), den));
			// smaller magnitude first; on a tie the (b+s) root stays first
			if (((t0 < 0) ? -t0 : t0) > ((t1 < 0) ? -t1 : t1)) begin
				res.near_d = t1[31:0];
				res.far_d = t0[31:0];
			end else begin
				res.near_d = t0[31:0];
				res.far_d = t1[31:0];
			end
		end
		return res;
	endfunction

	// ---------------- drivers ----------------
	task automatic cfg_write(input logic [rci_pkg::REG_IDX_BITS-1:0] idx,
			input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx < rci_pkg::NUM_REGS) cyl_regs[idx] = val;
		cfg_valid <= 1'b0;
	endtask

	// wait for the pipeline to drain before touching the registers
	task automatic wait_drained();
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_ray(input ray_row_t row);
		vec3_t org, dir;
		int    g;
		in_valid     <= 1'b1;
		ray_origin_x <= row.ox;
		ray_origin_y <= row.oy;
		ray_origin_z <= row.oz;
		ray_dir_x    <= row.dx;
		ray_dir_y    <= row.dy;
		ray_dir_z    <= row.dz;
		cmd          <= row.kind;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// transfer taken at this edge
		org = '{row.ox, row.oy, row.oz};
		dir = '{row.dx, row.dy, row.dz};
		if (row.known) pending_hits.push_back(row.res);
		else pending_hits.push_back(cylinder_hit(org, dir, row.kind));
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// receiver: random stall runs, result check on every transfer
	always @(posedge clk) begin
		isect_t e;
		if (stall_left == 0) begin
			out_stall  <= ($urandom_range(0, 3) == 0);
			stall_left <= gap_len();
		end else begin
			stall_left <= stall_left - 1;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_hits.size() == 0) begin
				$error("result transfer with nothing expected");
				fails++;
			end else begin
				e = pending_hits.pop_front();
				if (hit !== e.hit) begin
					$error("hit exp %0d got %0d", e.hit, hit);
					fails++;
				end
				if (near_dist !== e.near_d) begin
					$error("near_dist exp %0d got %0d", e.near_d, near_dist);
					fails++;
				end
				if (far_dist !== e.far_d) begin
					$error("far_dist exp %0d got %0d", e.far_d, far_dist);
					fails++;
				end
				if (parallel_flag !== e.par) begin
					$error("parallel_flag exp %0d got %0d", e.par, parallel_flag);
					fails++;
				end
				if (query_tag !== e.tag) begin
					$error("query_tag exp %0d got %0d", e.tag, query_tag);
					fails++;
				end
			end
		end
	end

	// ---------------- directed rows (reset cylinder: y axis, radius 1) ----------------
	localparam isect_t NO_RES = '{1'b0, 32'sd0, 32'sd0, 1'b0, 1'b0};
	ray_row_t directed [] = '{
		// straight through: 4.0 and 6.0
		'{0, 0, -5*ONE, 0, 0, ONE, 1'b0, 1'b1, '{1'b1, 4*ONE, 6*ONE, 1'b0, 1'b0}},
		// tangent: equal roots
		'{ONE, 0, -5*ONE, 0, 0, ONE, 1'b1, 1'b1, '{1'b1, 5*ONE, 5*ONE, 1'b0, 1'b1}},
		// miss
		'{5*ONE, 0, -5*ONE, 0, 0, ONE, 1'b0, 1'b1, '{1'b0, 0, 0, 1'b0, 1'b0}},
		// parallel to the axis
		'{0, 0, -5*ONE, 0, ONE, 0, 1'b1, 1'b1, '{1'b1, 0, 0, 1'b1, 1'b1}},
		// origin on the axis: equal magnitudes, negative root first
		'{0, 0, 0, 0, 0, ONE, 1'b0, 1'b1, '{1'b1, -ONE, ONE, 1'b0, 1'b0}},
		// zero direction behaves as parallel
		'{0, 0, -5*ONE, 0, 0, 0, 1'b1, 1'b1, '{1'b1, 0, 0, 1'b1, 1'b1}},
		// cylinder behind the ray: both roots negative
		'{0, 0, 5*ONE, 0, 0, ONE, 1'b0, 1'b1, '{1'b1, -4*ONE, -6*ONE, 1'b0, 1'b0}},
		// extremes and bit patterns, predicted
		'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 1'b1, 1'b0, NO_RES},
		'{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 1'b0, 1'b0, NO_RES},
		'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 1'b1, 1'b0, NO_RES},
		'{32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555,
			32'shaaaaaaaa, 1'b0, 1'b0, NO_RES},
		'{32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa,
			32'sh55555555, 1'b1, 1'b0, NO_RES},
		// nearly parallel rays: roots far away; the smallest direction reads as parallel
		'{0, 0, -5*ONE, 0, 0, 256, 1'b0, 1'b0, NO_RES},
		'{0, 0, -5*ONE, 0, 0, 1, 1'b1, 1'b0, NO_RES},
		'{ONE/2, 3*ONE, -ONE/3, ONE, -ONE, ONE/7, 1'b0, 1'b0, NO_RES},
		'{32'sh7fffffff, 0, 0, -ONE, 0, 0, 1'b1, 1'b0, NO_RES}
	};

	// ---------------- stimulus ----------------
	task automatic set_cylinder(input logic [31:0] v [rci_pkg::NUM_REGS]);
		cfg_write(rci_pkg::REG_AXIS_PX, v[0]);
		cfg_write(rci_pkg::REG_AXIS_PY, v[1]);
		cfg_write(rci_pkg::REG_AXIS_PZ, v[2]);
		cfg_write(rci_pkg::REG_AXIS_DX, v[3]);
		cfg_write(rci_pkg::REG_AXIS_DY, v[4]);
		cfg_write(rci_pkg::REG_AXIS_DZ, v[5]);
		cfg_write(rci_pkg::REG_RADIUS, v[6]);
	endtask

	function automatic logic signed [31:0] near_val(input logic [31:0] base, input int span);
		return base + $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	initial begin
		logic [31:0] v [rci_pkg::NUM_REGS];
		ray_row_t    row;
		cyl_regs = '{32'd0, 32'd0, 32'd0, 32'd0, rci_pkg::ONE_RST, 32'd0,
			{1'b0, rci_pkg::RADIUS_RST}};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_ray(directed[i]);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// sender holds off until every result is back
			in_valid <= 1'b0;
			wait_drained();
			case (ph)
				0: v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
					32'h7fffffff, 32'h7fffffff, 32'hffffffff};
				1: v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
					32'h00000000, 32'h00000000, 32'h00000000};
				2: v = '{$urandom, $urandom, $urandom, 32'd0, 32'd0, 32'd0, $urandom};
				3: v = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
				default: begin
					for (int i = 0; i < 3; i++) v[i] = near_val(0, 16 * ONE);
					for (int i = 3; i < 6; i++) v[i] = near_val(0, 4 * ONE);
					v[6] = $urandom_range(0, 6 * ONE) | ($urandom_range(0, 1) << 31);
				end
			endcase
			set_cylinder(v);
			// writes beyond the map must be dropped
			if (ph == 4) cfg_write(REG_UNMAPPED, $urandom);
			for (int k = 0; k < PER_PHASE; k++) begin
				row.kind = $urandom_range(0, 1);
				row.known = 1'b0;
				row.res = NO_RES;
				if ($urandom_range(0, 9) < 7) begin
					// rays aimed around the cylinder
					row.ox = near_val(cyl_regs[0], 12 * ONE);
					row.oy = near_val(cyl_regs[1], 12 * ONE);
					row.oz = near_val(cyl_regs[2], 12 * ONE);
					row.dx = near_val(0, 3 * ONE);
					row.dy = near_val(0, 3 * ONE);
					row.dz = near_val(0, 3 * ONE);
				end else begin
					row.ox = $urandom;
					row.oy = $urandom;
					row.oz = $urandom;
					row.dx = $urandom;
					row.dy = $urandom;
					row.dz = $urandom;
				end
				send_ray(row);
			end
		end

		in_valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- ray_cylinder_intersect.f -----
hdl/rci_pkg.sv
hdl/ray_cylinder_intersect.sv
dv/tb_top.sv
